[src/cdsc_pkg.sv]
// Shared types, constants and calendar functions for the date step counter.
`default_nettype none

package cdsc_pkg;

  localparam int YEAR_BITS = 12;

  typedef logic [YEAR_BITS-1:0] year_t;
  typedef logic [4:0]           day_t;
  typedef logic [3:0]           month_t;

  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
  } date_t;

  typedef enum logic [1:0] {
    OP_NEXT = 2'd0,
    OP_PREV = 2'd1,
    OP_SET  = 2'd2
  } op_t;

  localparam year_t  YEAR_MIN  = year_t'(1900);
  localparam year_t  YEAR_MAX  = '1;
  localparam day_t   DAY_FIRST = 5'd1;
  localparam day_t   DAY_LAST  = 5'd31;
  localparam month_t MONTH_JAN = 4'd1;
  localparam month_t MONTH_FEB = 4'd2;
  localparam month_t MONTH_APR = 4'd4;
  localparam month_t MONTH_JUN = 4'd6;
  localparam month_t MONTH_SEP = 4'd9;
  localparam month_t MONTH_NOV = 4'd11;
  localparam month_t MONTH_DEC = 4'd12;

  // 25 * INV25 == 1 modulo 2^YEAR_BITS; y is a multiple of 25 exactly when
  // y * INV25 (mod 2^YEAR_BITS) is no more than floor((2^YEAR_BITS - 1) / 25).
  // The inverse modulo 2^16, truncated, is the inverse for any smaller width.
  localparam int    INV25_16    = 23593;
  localparam year_t INV25       = year_t'(INV25_16);
  localparam year_t DIV25_LIMIT = year_t'(((1 << YEAR_BITS) - 1) / 25);

  localparam date_t DATE_RESET = '{day: DAY_FIRST, month: MONTH_JAN, year: YEAR_MIN};

  // Leap when divisible by 4 and not by 100, or divisible by 400.
  function automatic logic is_leap(year_t y);
    year_t prod;
    logic  div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_LIMIT);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic day_t month_len(month_t m, year_t y);
    day_t len;
    len = DAY_LAST;
    if (m == MONTH_FEB) begin
      len = is_leap(y) ? 5'd29 : 5'd28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

[src/cdsc_step.sv]
// Next-date logic: next day, previous day and validated load.
`default_nettype none

module cdsc_step (
  input  wire logic [1:0]      operation,
  input  wire cdsc_pkg::date_t new_date,
  input  wire cdsc_pkg::date_t cur_date,
  output cdsc_pkg::date_t      date_next,
  output logic                 set_accepted,
  output logic                 limit_hit
);
  import cdsc_pkg::*;

  day_t   cur_len;
  day_t   prev_len;
  day_t   new_len;
  month_t prev_month;
  logic   new_valid;

  assign cur_len    = month_len(cur_date.month, cur_date.year);
  assign prev_month = cur_date.month - 4'd1;
  assign prev_len   = month_len(prev_month, cur_date.year);
  assign new_len    = month_len(new_date.month, new_date.year);

  assign new_valid = (new_date.month >= MONTH_JAN) && (new_date.month <= MONTH_DEC) &&
                     (new_date.year >= YEAR_MIN) && (new_date.day >= DAY_FIRST) &&
                     (new_date.day <= new_len);

  always_comb begin
    date_next    = cur_date;
    set_accepted = 1'b0;
    limit_hit    = 1'b0;
    case (operation)
      OP_NEXT: begin
        if (cur_date.day < cur_len) begin
          date_next.day = cur_date.day + 5'd1;
        end else if (cur_date.month < MONTH_DEC) begin
          date_next.day   = DAY_FIRST;
          date_next.month = cur_date.month + 4'd1;
        end else if (cur_date.year < YEAR_MAX) begin
          date_next.day   = DAY_FIRST;
          date_next.month = MONTH_JAN;
          date_next.year  = cur_date.year + year_t'(1);
        end else begin
          limit_hit = 1'b1;
        end
      end
      OP_PREV: begin
        if (cur_date.day > DAY_FIRST) begin
          date_next.day = cur_date.day - 5'd1;
        end else if (cur_date.month > MONTH_JAN) begin
          date_next.month = prev_month;
          date_next.day   = prev_len;
        end else if (cur_date.year > YEAR_MIN) begin
          date_next.year  = cur_date.year - year_t'(1);
          date_next.month = MONTH_DEC;
          date_next.day   = DAY_LAST;
        end else begin
          limit_hit = 1'b1;
        end
      end
      OP_SET: begin
        if (new_valid) begin
          date_next    = new_date;
          set_accepted = 1'b1;
        end
      end
      default: begin
        // unused code: hold the date, no flags
      end
    endcase
  end

endmodule

`default_nettype wire

[src/calendar_date_step_counter_top.sv]
// Top level of the calendar date step counter: input stage, date state, result stage.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid, in_ready | operation, new_day, new_month, new_year
//   out     | out_valid,out_ready| cur_day, cur_month, cur_year, set_accepted, limit_hit
//
// One item per clock sustained while out_ready is high.
// The date update is combinational between the input register and the result register.
// Reset sets the date to 1 Jan 1900 and empties both stages.
// A stalled result holds; the input register still takes one more item behind it.
`default_nettype none

module calendar_date_step_counter_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    operation,
  input  wire logic [4:0]                    new_day,
  input  wire logic [3:0]                    new_month,
  input  wire logic [cdsc_pkg::YEAR_BITS-1:0] new_year,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [4:0]                         cur_day,
  output logic [3:0]                         cur_month,
  output logic [cdsc_pkg::YEAR_BITS-1:0]     cur_year,
  output logic                               set_accepted,
  output logic                               limit_hit
);
  import cdsc_pkg::*;

  logic       s1_valid;
  logic [1:0] s1_operation;
  date_t      s1_date;
  date_t      date_reg;
  date_t      date_next;
  logic       accepted_next;
  logic       limit_next;
  logic       s1_go;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  cdsc_step u_step (
    .operation    (s1_operation),
    .new_date     (s1_date),
    .cur_date     (date_reg),
    .date_next    (date_next),
    .set_accepted (accepted_next),
    .limit_hit    (limit_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      date_reg  <= DATE_RESET;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
        date_reg  <= date_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_operation  <= operation;
      s1_date.day   <= new_day;
      s1_date.month <= new_month;
      s1_date.year  <= new_year;
    end
    if (s1_go) begin
      cur_day      <= date_next.day;
      cur_month    <= date_next.month;
      cur_year     <= date_next.year;
      set_accepted <= accepted_next;
      limit_hit    <= limit_next;
    end
  end

`ifndef SYNTHESIS
  a_date_in_range: assert property (@(posedge clk) disable iff (rst)
    (date_reg.month >= MONTH_JAN) && (date_reg.month <= MONTH_DEC) &&
    (date_reg.year >= YEAR_MIN) && (date_reg.day >= DAY_FIRST))
    else $error("date register out of range");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(set_accepted && limit_hit))
    else $error("set_accepted and limit_hit both high");

  a_limit_at_edge: assert property (@(posedge clk) disable iff (rst)
    (out_valid && limit_hit) |->
      ((cur_day == DAY_FIRST && cur_month == MONTH_JAN && cur_year == YEAR_MIN) ||
       (cur_day == DAY_LAST && cur_month == MONTH_DEC && cur_year == YEAR_MAX)))
    else $error("limit_hit away from a limit date");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    $past(s1_go) && !$past(rst) |->
      (cur_day == date_reg.day && cur_month == date_reg.month && cur_year == date_reg.year))
    else $error("result does not match date register");
`endif

endmodule

`default_nettype wire

[verif/calendar_date_step_counter_top_tb.sv]
// Self-checking testbench for the calendar date step counter top level.
`timescale 1ns / 1ps

module calendar_date_step_counter_top_tb;
  import cdsc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int YR_MIN = int'(YEAR_MIN);
  localparam int YR_MAX = int'(YEAR_MAX);
  localparam int IDLE_PCT = 19;
  localparam int RANDOM_ITEMS = 1050;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DIRECTED_ROWS = 26;

  typedef struct {
    int day;
    int month;
    int year;
    bit accepted;
    bit limit_held;
  } cal_result_t;

  typedef struct {
    logic [1:0] op;
    int d;
    int m;
    int y;
    bit typed;
    int xd;
    int xm;
    int xy;
    bit xacc;
    bit xlim;
  } date_row_t;

  // Rows with typed set carry their own expected date; the rest use the predictor.
  date_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_PREV,   31, 15, 4095, 1,  1,  1, 1900, 0, 1},
    '{OP_NEXT,    0,  0,    0, 1,  2,  1, 1900, 0, 0},
    '{OP_SET,    31, 12, 4095, 1, 31, 12, 4095, 1, 0},
    '{OP_NEXT,    0,  0,    0, 1, 31, 12, 4095, 0, 1},
    '{OP_UNUSED, 31, 15, 4095, 1, 31, 12, 4095, 0, 0},
    '{OP_PREV,    0,  0,    0, 0,  0,  0,    0, 0, 0},
    '{OP_SET,    29,  2, 1900, 1, 30, 12, 4095, 0, 0},
    '{OP_SET,    29,  2, 2000, 1, 29,  2, 2000, 1, 0},
    '{OP_NEXT,    0,  0,    0, 0,  0,  0,    0, 0, 0},
    '{OP_PREV,    0,  0,    0, 0,  0,  0,    0, 0, 0},
    '{OP_SET,     0,  5, 2020, 1, 29,  2, 2000, 0, 0},
    '{OP_SET,     1,  0, 2020, 1, 29,  2, 2000, 0, 0},
    '{OP_SET,     1, 13, 2020, 1, 29,  2, 2000, 0, 0},
    '{OP_SET,     1, 15, 2020, 1, 29,  2, 2000, 0, 0},
    '{OP_SET,     1,  1, 1899, 1, 29,  2, 2000, 0, 0},
    '{OP_SET,    31,  4, 2021, 1, 29,  2, 2000, 0, 0},
    '{OP_SET,     1,  8, 2021, 1,  1,  8, 2021, 1, 0},
    '{OP_PREV,    0,  0,    0, 0,  0,  0,    0, 0, 0},
    '{OP_SET,    28,  2, 2100, 1, 28,  2, 2100, 1, 0},
    '{OP_NEXT,    0,  0,    0, 0,  0,  0,    0, 0, 0},
    '{OP_SET,    31, 12, 1999, 1, 31, 12, 1999, 1, 0},
    '{OP_NEXT,    0,  0,    0, 0,  0,  0,    0, 0, 0},
    '{OP_SET,     1,  3, 2024, 1,  1,  3, 2024, 1, 0},
    '{OP_PREV,    0,  0,    0, 0,  0,  0,    0, 0, 0},
    '{OP_SET,     1,  1, 1900, 1,  1,  1, 1900, 1, 0},
    '{OP_PREV,    0,  0,    0, 1,  1,  1, 1900, 0, 1}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           operation = OP_NEXT;
  logic [4:0]           new_day = '0;
  logic [3:0]           new_month = '0;
  logic [YEAR_BITS-1:0] new_year = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [4:0]           cur_day;
  logic [3:0]           cur_month;
  logic [YEAR_BITS-1:0] cur_year;
  logic                 set_accepted;
  logic                 limit_hit;

  // Predicted date state
  int cal_day = 1;
  int cal_month = 1;
  int cal_year = YR_MIN;

  cal_result_t pending_dates[$];
  cal_result_t expected_res;
  bit steady = 1'b0;
  int errors = 0;
  int results_checked = 0;
  int idle_cycles = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int loads_seen = 0;
  int limits_seen = 0;

  calendar_date_step_counter_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .new_day     (new_day),
    .new_month   (new_month),
    .new_year    (new_year),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cur_day     (cur_day),
    .cur_month   (cur_month),
    .cur_year    (cur_year),
    .set_accepted(set_accepted),
    .limit_hit   (limit_hit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in(int m, int y);
    if (m == 2) begin
      return leap_year(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic bit date_ok(int d, int m, int y);
    if (m < 1 || m > 12 || y < YR_MIN || y > YR_MAX || d < 1) begin
      return 1'b0;
    end
    return d <= days_in(m, y);
  endfunction

  task automatic step_calendar(input logic [1:0] op, input int d, input int m, input int y,
                               output cal_result_t r);
    r.accepted = 1'b0;
    r.limit_held = 1'b0;
    case (op)
      OP_NEXT: begin
        if (cal_day < days_in(cal_month, cal_year)) begin
          cal_day++;
        end else if (cal_month < 12) begin
          cal_day = 1;
          cal_month++;
        end else if (cal_year < YR_MAX) begin
          cal_day = 1;
          cal_month = 1;
          cal_year++;
        end else begin
          r.limit_held = 1'b1;
        end
      end
      OP_PREV: begin
        if (cal_day > 1) begin
          cal_day--;
        end else if (cal_month > 1) begin
          cal_month--;
          cal_day = days_in(cal_month, cal_year);
        end else if (cal_year > YR_MIN) begin
          cal_year--;
          cal_month = 12;
          cal_day = 31;
        end else begin
          r.limit_held = 1'b1;
        end
      end
      OP_SET: begin
        if (date_ok(d, m, y)) begin
          cal_day = d;
          cal_month = m;
          cal_year = y;
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    r.day = cal_day;
    r.month = cal_month;
    r.year = cal_year;
  endtask

  // Drive one item, hold it until taken, then queue its expected date.
  task automatic send_item(input logic [1:0] op, input int d, input int m, input int y,
                           input bit typed, input cal_result_t typed_res);
    cal_result_t res;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    new_day   <= d[4:0];
    new_month <= m[3:0];
    new_year  <= y[YEAR_BITS-1:0];
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    step_calendar(op, d, m, y, res);
    pending_dates.push_back(typed ? typed_res : res);
    op_count[op]++;
    loads_seen += res.accepted;
    limits_seen += res.limit_held;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Check results in order and watch for a stalled handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_dates.size() == 0) begin
          errors++;
          $display("%0t: result %0d/%0d/%0d with no item outstanding", $time,
                   cur_day, cur_month, cur_year);
        end else begin
          expected_res = pending_dates.pop_front();
          check_field("cur_day", expected_res.day, cur_day);
          check_field("cur_month", expected_res.month, cur_month);
          check_field("cur_year", expected_res.year, cur_year);
          check_field("set_accepted", expected_res.accepted, set_accepted);
          check_field("limit_hit", expected_res.limit_held, limit_hit);
        end
        results_checked++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("** calendar_date_step_counter_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int k;
    int sel;
    int d;
    int m;
    int y;
    int len;
    logic [1:0] op;
    cal_result_t typed_res;
    cal_result_t no_typed;

    no_typed = '{0, 0, 0, 1'b0, 1'b0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      typed_res = '{directed_rows[i].xd, directed_rows[i].xm, directed_rows[i].xy,
                    directed_rows[i].xacc, directed_rows[i].xlim};
      send_item(directed_rows[i].op, directed_rows[i].d, directed_rows[i].m,
                directed_rows[i].y, directed_rows[i].typed, typed_res);
    end
    drain_results();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 300 && i < 550);
      if (i == 700) begin
        drain_results();
      end
      k = $urandom_range(0, 99);
      d = $urandom_range(0, 31);
      m = $urandom_range(0, 15);
      y = $urandom_range(0, YR_MAX);
      if (k < 38) begin
        op = OP_NEXT;
      end else if (k < 70) begin
        op = OP_PREV;
      end else if (k < 74) begin
        op = OP_UNUSED;
      end else begin
        op = OP_SET;
        if (k < 90) begin
          sel = $urandom_range(0, 11);
          case (sel)
            0: begin
              y = YR_MAX;
              m = 12;
              d = $urandom_range(30, 31);
            end
            1: begin
              y = YR_MIN;
              m = 1;
              d = $urandom_range(1, 2);
            end
            default: begin
              if (sel == 2) begin
                y = $urandom_range(YR_MAX - 5, YR_MAX);
              end else if (sel == 3) begin
                y = $urandom_range(YR_MIN, YR_MIN + 5);
              end else if (sel == 4) begin
                y = $urandom_range(19, YR_MAX / 100) * 100;
              end else if (sel == 5) begin
                y = YR_MIN + 4 * $urandom_range(0, (YR_MAX - YR_MIN) / 4);
              end else begin
                y = $urandom_range(YR_MIN, YR_MAX);
              end
              m = $urandom_range(1, 12);
              len = days_in(m, y);
              // favor month ends so the steps cross month and year boundaries
              d = $urandom_range(0, 1) ? len - $urandom_range(0, 1) : $urandom_range(1, len);
            end
          endcase
        end else if (k < 95) begin
          // one day past the end of a real month (day 0 after a 31-day month)
          m = $urandom_range(1, 12);
          y = $urandom_range(YR_MIN, YR_MAX);
          d = days_in(m, y) + 1;
          if (d > 31) begin
            d = 0;
          end
        end
      end
      send_item(op, d, m, y, 1'b0, no_typed);
    end
    steady = 1'b0;
    drain_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d items: %0d next, %0d previous, %0d set (%0d loaded), %0d unused code.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[OP_NEXT],
             op_count[OP_PREV], op_count[OP_SET], loads_seen, op_count[OP_UNUSED]);
    $display("Checked %0d results, %0d of them holding at a date limit; %0d errors.",
             results_checked, limits_seen, errors);
    if (errors == 0) begin
      $display("** calendar_date_step_counter_top: PASSED **");
    end else begin
      $display("** calendar_date_step_counter_top: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
src/cdsc_pkg.sv
src/cdsc_step.sv
src/calendar_date_step_counter_top.sv
verif/calendar_date_step_counter_top_tb.sv
